### sv/tle_pkg.sv
// Shared types, codes and constants of the terminal line editor.
package tle_pkg;

   localparam int LINE_DEPTH = 256;
   localparam logic [8:0] ROOM_MAX = (LINE_DEPTH < 256) ? 9'(LINE_DEPTH) : 9'd256;

   localparam int OPQ_DEPTH = 4;
   localparam int OPQ_AW    = 2;

   // Configuration register indexes.
   localparam logic CSR_ECHO_ENABLE   = 1'b0;
   localparam logic CSR_LINE_CAPACITY = 1'b1;

   // Input actions.
   localparam logic ACTION_RX   = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   // Operation codes passed from the front to the back.
   localparam logic [2:0] OP_READ     = 3'd0;
   localparam logic [2:0] OP_LINE_END = 3'd1;
   localparam logic [2:0] OP_ERASE    = 3'd2;
   localparam logic [2:0] OP_CTRL_C   = 3'd3;
   localparam logic [2:0] OP_PRINT    = 3'd4;

   // Character codes.
   localparam logic [7:0] CH_CTRL_C = 8'h03;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_IAC    = 8'hFF;

   localparam logic [1:0] IAC_SKIP  = 2'd2;

   typedef struct packed {
      logic [2:0] code;
      logic       echo;
      logic [7:0] byte_val;
      logic [7:0] index;
   } op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] len;
      logic       last;
   } rsp_type;

endpackage

### sv/terminal_line_editor.sv
// Top level of the terminal line editor: ports, configuration registers and part wiring.
//
// Channel   Direction  Transfer condition        Payload
// req       in         req_push & !req_full      req_action, req_rx_byte, req_read_index
// rsp       out        rsp_pop & !rsp_empty      rsp_result_kind, rsp_data_byte,
//                                                rsp_line_length, rsp_last
// csr       in         csr_valid & csr_ready     csr_index, csr_wdata
//
// An item is taken whenever the four-entry operation queue has room.
// The result sequencer emits one result per cycle while the output buffer has room, so an
// item with n results (one to four) holds it until all are out; store read data is registered.
// Reset clears the line state, queues and registers; the line store is not cleared.
// A stalled rsp side fills the two-entry output buffer, then the operation queue.
module terminal_line_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_read_index,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_line_length,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);
   import tle_pkg::*;

   logic       echo_enable_ff;
   logic [8:0] line_capacity_ff;
   logic       req_accept;
   logic       op_valid;
   op_type     front_op;
   op_type     head_op;
   logic       opq_empty;
   logic       opq_pop;
   rsp_type    rsp;

   assign csr_ready  = 1'b1;
   assign req_accept = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_enable_ff   <= 1'b1;
         line_capacity_ff <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ECHO_ENABLE:   echo_enable_ff   <= csr_wdata[0];
            CSR_LINE_CAPACITY: line_capacity_ff <= csr_wdata;
            default:           echo_enable_ff   <= echo_enable_ff;
         endcase
      end
   end

   tle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .action        (req_action),
      .rx_byte       (req_rx_byte),
      .read_index    (req_read_index),
      .echo_enable   (echo_enable_ff),
      .line_capacity (line_capacity_ff),
      .op_valid      (op_valid),
      .op            (front_op)
   );

   tle_opq u_opq (
      .clock   (clock),
      .reset   (reset),
      .push    (op_valid),
      .push_op (front_op),
      .full    (req_full),
      .pop     (opq_pop),
      .head_op (head_op),
      .empty   (opq_empty)
   );

   tle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (head_op),
      .opq_empty (opq_empty),
      .opq_pop   (opq_pop),
      .rsp       (rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_result_kind = rsp.kind;
   assign rsp_data_byte   = rsp.data;
   assign rsp_line_length = rsp.len;
   assign rsp_last        = rsp.last;

endmodule

### sv/tle_front.sv
// Front part: line state tracking and classification of accepted items into operations.
module tle_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                action,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          read_index,
   input  logic                echo_enable,
   input  logic [8:0]          line_capacity,
   output logic                op_valid,
   output tle_pkg::op_type     op
);
   import tle_pkg::*;

   logic [7:0] count_ff, count_in;
   logic       drop_lf_ff, drop_lf_in;
   logic [1:0] skip_ff, skip_in;
   logic [8:0] room;
   logic       has_room;

   assign room     = (line_capacity > ROOM_MAX) ? ROOM_MAX : line_capacity;
   assign has_room = ({1'b0, count_ff} + 9'd1) < room;

   always_comb begin
      count_in     = count_ff;
      drop_lf_in   = drop_lf_ff;
      skip_in      = skip_ff;
      op_valid     = 1'b0;
      op.code      = OP_READ;
      op.echo      = echo_enable;
      op.byte_val  = rx_byte;
      op.index     = count_ff;
      if (accept) begin
         if (action == ACTION_READ) begin
            op_valid = 1'b1;
            op.index = read_index;
         end else if (skip_ff != 2'd0) begin
            skip_in = skip_ff - 2'd1;
         end else if (drop_lf_ff && rx_byte == CH_LF) begin
            drop_lf_in = 1'b0;
         end else begin
            drop_lf_in = 1'b0;
            case (rx_byte)
               CH_IAC: begin
                  skip_in = IAC_SKIP;
               end
               CH_CR, CH_LF: begin
                  drop_lf_in = (rx_byte == CH_CR);
                  op_valid   = 1'b1;
                  op.code    = OP_LINE_END;
                  count_in   = 8'd0;
               end
               CH_DEL, CH_BS: begin
                  if (count_ff != 8'd0) begin
                     count_in = count_ff - 8'd1;
                     op_valid = echo_enable;
                     op.code  = OP_ERASE;
                  end
               end
               CH_CTRL_C: begin
                  op_valid = 1'b1;
                  op.code  = OP_CTRL_C;
                  count_in = 8'd0;
               end
               default: begin
                  if (rx_byte >= CH_SPACE && has_room) begin
                     // The store is written in the back part, even with echo off.
                     op_valid = 1'b1;
                     op.code  = OP_PRINT;
                     count_in = count_ff + 8'd1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 8'd0;
         drop_lf_ff <= 1'b0;
         skip_ff    <= 2'd0;
      end else begin
         count_ff   <= count_in;
         drop_lf_ff <= drop_lf_in;
         skip_ff    <= skip_in;
      end
   end

endmodule

### sv/tle_opq.sv
// Short operation queue between the front and back parts.
module tle_opq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tle_pkg::op_type   push_op,
   output logic              full,
   input  logic              pop,
   output tle_pkg::op_type   head_op,
   output logic              empty
);
   import tle_pkg::*;

   op_type                mem_ff [OPQ_DEPTH];
   logic [OPQ_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [OPQ_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [OPQ_AW:0]       cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = (cnt_ff == (OPQ_AW + 1)'(OPQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### sv/tle_back.sv
// Back part: line store, result sequencer and output buffer.
module tle_back (
   input  logic              clock,
   input  logic              reset,
   input  tle_pkg::op_type   head_op,
   input  logic              opq_empty,
   output logic              opq_pop,
   output tle_pkg::rsp_type  rsp,
   output logic              rsp_empty,
   input  logic              rsp_pop
);
   import tle_pkg::*;

   logic [7:0] store_mem [LINE_DEPTH];
   logic [7:0] rdata_ff;

   logic       exec_valid_ff, exec_valid_in;
   op_type     exec_op_ff;
   logic [1:0] step_ff, step_in;
   logic [1:0] end_ff;
   logic [1:0] start_step, end_step;
   logic       produces;

   rsp_type    res;
   logic       res_last;
   logic       out_ready;
   logic       out_push, out_pop;

   rsp_type    out_mem_ff [2];
   logic       out_wr_ff, out_rd_ff;
   logic [1:0] out_cnt_ff, out_cnt_in;

   // Sequence bounds of the operation at the queue head.
   always_comb begin
      start_step = 2'd0;
      end_step   = 2'd0;
      produces   = 1'b1;
      case (head_op.code)
         OP_LINE_END: begin
            start_step = head_op.echo ? 2'd0 : 2'd2;
            end_step   = 2'd2;
         end
         OP_ERASE:  end_step = 2'd2;
         OP_CTRL_C: end_step = 2'd3;
         OP_PRINT:  produces = head_op.echo;
         default:   end_step = 2'd0;
      endcase
   end

   // Result for the current step of the operation in execution.
   always_comb begin
      res.kind = KIND_ECHO;
      res.data = 8'd0;
      res.len  = 8'd0;
      case (exec_op_ff.code)
         OP_LINE_END: begin
            case (step_ff)
               2'd0:    res.data = CH_CR;
               2'd1:    res.data = CH_LF;
               default: begin
                  res.kind = KIND_LINE;
                  res.len  = exec_op_ff.index;
               end
            endcase
         end
         OP_ERASE: begin
            res.data = (step_ff == 2'd1) ? CH_SPACE : CH_BS;
         end
         OP_CTRL_C: begin
            case (step_ff)
               2'd0:    res.data = CH_CARET;
               2'd1:    res.data = CH_UPPER_C;
               2'd2:    res.data = CH_CR;
               default: res.data = CH_LF;
            endcase
         end
         OP_PRINT: begin
            res.data = exec_op_ff.byte_val;
         end
         default: begin
            res.kind = KIND_READ;
            res.data = rdata_ff;
         end
      endcase
      res_last = (step_ff == end_ff);
      res.last = res_last;
   end

   assign out_ready = (out_cnt_ff != 2'd2) || rsp_pop;
   assign out_push  = exec_valid_ff && out_ready;
   assign out_pop   = rsp_pop && !rsp_empty;
   assign opq_pop   = !opq_empty && (!exec_valid_ff || (out_push && res_last));

   always_comb begin
      exec_valid_in = exec_valid_ff;
      step_in       = step_ff;
      if (out_push) begin
         if (res_last) begin
            exec_valid_in = 1'b0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
      if (opq_pop && produces) begin
         exec_valid_in = 1'b1;
         step_in       = start_step;
      end
   end

   // Store writes and reads happen as an operation leaves the queue, so they keep item order.
   always_ff @(posedge clock) begin
      if (opq_pop) begin
         if (head_op.code == OP_PRINT) begin
            store_mem[head_op.index] <= head_op.byte_val;
         end
         if (head_op.code == OP_READ) begin
            rdata_ff <= store_mem[head_op.index];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (opq_pop && produces) begin
         exec_op_ff <= head_op;
         end_ff     <= end_step;
      end
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= res;
      end
   end

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   assign rsp       = out_mem_ff[out_rd_ff];
   assign rsp_empty = (out_cnt_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         step_ff       <= 2'd0;
         out_wr_ff     <= 1'b0;
         out_rd_ff     <= 1'b0;
         out_cnt_ff    <= 2'd0;
      end else begin
         exec_valid_ff <= exec_valid_in;
         step_ff       <= step_in;
         out_wr_ff     <= out_push ? ~out_wr_ff : out_wr_ff;
         out_rd_ff     <= out_pop ? ~out_rd_ff : out_rd_ff;
         out_cnt_ff    <= out_cnt_in;
      end
   end

endmodule
